[hw/rtl/erf_pkg.sv]
// shared constants, register indexes and reset values for the edge replicated fir filter
`default_nettype none
package erf_pkg;

  localparam int MAX_HALF        = 3;
  localparam int DEPTH           = 2 * MAX_HALF + 1;
  localparam int NUM_COEF        = 7;
  localparam int COEF_W          = 16;
  localparam int HALF_W          = 2;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_FRAC_BITS  = 15;

  // register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HALF_WIDTH = 3'd0,
    REG_COEF_0     = 3'd1,
    REG_COEF_1     = 3'd2,
    REG_COEF_2     = 3'd3,
    REG_COEF_3     = 3'd4,
    REG_COEF_4     = 3'd5,
    REG_COEF_5     = 3'd6,
    REG_COEF_6     = 3'd7
  } reg_index_t;

  localparam logic [HALF_W-1:0] HALF_RESET = 2'd1;

  typedef logic signed [COEF_W-1:0] coef_t;

  function automatic coef_t coef_reset(input int j);
    coef_t v;
    unique case (j)
      0:       v = 16'sd8192;
      1:       v = 16'sd16384;
      2:       v = 16'sd8192;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/edge_replicated_fir_filter_core.sv]
// line fir filter with clamped edges, product register and output register
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: sample; tlast: line end
//  out_    | out | out_tvalid/tready  | tdata: filtered; tlast: last output of line
//  cfg_    | in  | cfg_valid/ready    | cfg_index: register, cfg_data: value
//
// one sample is taken per cycle while the product stage has room; after a line end,
// in_tready is low while up to h further outputs, one for each position still pending, are flushed.
// tap products are registered, then sum, round and
// saturate feed the output register.
// rst_n is synchronous; it restores the register reset values and the line start.
// a stalled output holds its result; the product stage keeps moving while it has room.
`default_nettype none
module edge_replicated_fir_filter_core
  import erf_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = erf_pkg::SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = erf_pkg::COEF_FRAC_BITS,
  localparam int TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire  [TDATA_W-1:0]       in_tdata,   // [SAMPLE_WIDTH-1:0] sample, rest zero
  input  wire                      in_tlast,   // line_end
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output logic [TDATA_W-1:0]       out_tdata,  // [SAMPLE_WIDTH-1:0] filtered, rest zero
  output logic                     out_tlast,  // last
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]    cfg_data
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = (PROD_W + 3 > COEF_FRAC_BITS + 2) ? PROD_W + 3 : COEF_FRAC_BITS + 2;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;
  typedef logic signed [PROD_W-1:0]       prod_t;

  // configuration
  logic [HALF_W-1:0] half_r;
  coef_t             coef_r [NUM_COEF];

  // front end
  smp_t              window_r   [DEPTH];
  smp_t              window_nxt [DEPTH];
  smp_t              win_base   [DEPTH];
  logic [FILL_W-1:0] filled_r, filled_nxt;
  logic [HALF_W-1:0] rem_r, rem_nxt;

  // product stage
  prod_t             prod_r   [NUM_COEF];
  prod_t             prod_nxt [NUM_COEF];
  logic              p_valid_r, p_last_r;
  logic              p_valid_nxt, p_last_nxt;

  // output stage
  logic              out_valid_r, out_last_r;
  smp_t              out_data_r, out_data_nxt;

  logic              o_ready, p_ready, in_xfer, flushing, advance;
  smp_t              in_sample;
  logic [FILL_W-1:0] filled_inc;
  logic [HALF_W-1:0] count, pre;
  logic              fits;
  logic [IDX_W:0]    tap_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
      for (int j = 0; j < NUM_COEF; j++) coef_r[j] <= coef_reset(j);
    end else if (cfg_valid) begin
      if (cfg_index == REG_HALF_WIDTH) begin
        half_r <= cfg_data[HALF_W-1:0];
      end else begin
        coef_r[cfg_index - CFG_INDEX_W'(1)] <= cfg_data[COEF_W-1:0];
      end
    end
  end

  assign o_ready   = !out_valid_r || out_tready;
  assign p_ready   = !p_valid_r || o_ready;
  assign flushing  = (rem_r != '0);
  assign in_tready = !flushing && p_ready;
  assign in_xfer   = in_tvalid && in_tready;
  assign advance   = in_xfer || (flushing && p_ready);
  assign in_sample = in_tdata[SAMPLE_WIDTH-1:0];

  always_comb begin
    filled_inc = (filled_r == FILL_FULL) ? FILL_FULL : filled_r + FILL_W'(1);
    fits       = filled_inc > FILL_W'(half_r);
    count      = fits ? half_r + HALF_W'(1) : filled_inc[HALF_W-1:0];
    pre        = fits ? '0 : half_r + HALF_W'(1) - filled_inc[HALF_W-1:0];

    // first sample of a line fills every entry, otherwise shift by one
    for (int i = 0; i < DEPTH - 1; i++) begin
      win_base[i] = (!flushing && filled_r == '0) ? in_sample : window_r[i+1];
    end
    win_base[DEPTH-1] = flushing ? window_r[DEPTH-1] : in_sample;

    // short line: extra shifts of the last sample before the first output
    for (int i = 0; i < DEPTH; i++) begin
      window_nxt[i] = win_base[i];
      if (!flushing && in_tlast) begin
        if (i + int'(pre) < DEPTH) window_nxt[i] = win_base[i + int'(pre)];
        else                       window_nxt[i] = in_sample;
      end
    end

    if (flushing) begin
      filled_nxt  = filled_r;
      rem_nxt     = rem_r - HALF_W'(1);
      p_valid_nxt = 1'b1;
      p_last_nxt  = (rem_r == HALF_W'(1));
    end else if (in_tlast) begin
      filled_nxt  = '0;
      rem_nxt     = count - HALF_W'(1);
      p_valid_nxt = 1'b1;
      p_last_nxt  = (count == HALF_W'(1));
    end else begin
      filled_nxt  = filled_inc;
      rem_nxt     = '0;
      p_valid_nxt = fits;
      p_last_nxt  = 1'b0;
    end

    // tap j meets window entry DEPTH-1-2h+j, taps above 2h are off
    for (int j = 0; j < NUM_COEF; j++) begin
      tap_idx = (IDX_W + 1)'(DEPTH - 1 + j) - (IDX_W + 1)'({half_r, 1'b0});
      if (j <= 2 * int'(half_r) && j < DEPTH) begin
        prod_nxt[j] = window_nxt[tap_idx[IDX_W-1:0]] * coef_r[j];
      end else begin
        prod_nxt[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r  <= '0;
      rem_r     <= '0;
      p_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        filled_r <= filled_nxt;
        rem_r    <= rem_nxt;
      end
      if (p_ready) p_valid_r <= advance && p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < DEPTH; i++) window_r[i] <= window_nxt[i];
    end
    if (p_ready) begin
      for (int j = 0; j < NUM_COEF; j++) prod_r[j] <= prod_nxt[j];
      p_last_r <= p_last_nxt;
    end
  end

  // sum, round half up, saturate
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    acc = ROUND_ADD;
    for (int j = 0; j < NUM_COEF; j++) acc = acc + ACC_W'(prod_r[j]);
    shifted = acc >>> COEF_FRAC_BITS;
    priority if (shifted > SAT_MAX) out_data_nxt = SAT_MAX[SAMPLE_WIDTH-1:0];
    else if (shifted < SAT_MIN)     out_data_nxt = SAT_MIN[SAMPLE_WIDTH-1:0];
    else                            out_data_nxt = shifted[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && p_valid_r) begin
      out_data_r <= out_data_nxt;
      out_last_r <= p_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'($unsigned(out_data_r));
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the edge replicated fir line filter core
module tb_top;
  import erf_pkg::*;

  localparam int TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 10;
  localparam int RAND_ITEMS = 85;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           last;
  } line_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TDATA_W-1:0]     in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [TDATA_W-1:0]     out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  edge_replicated_fir_filter_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter state as the block should hold it
  logic [HALF_W-1:0] half_q;
  sample_t           coef_q [NUM_COEF];
  sample_t           tap_line [DEPTH];
  int                line_fill;
  line_result_t      filtered_expected [$];
  sample_t           kernel_plan [NUM_COEF];

  int  mismatch_count = 0;
  int  samples_sent = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  no_gaps = 1'b0;
  bit  no_stalls = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic sample_t tap_sum(int h);
    longint acc;
    acc = 0;
    for (int j = 0; j <= 2 * h; j++)
      acc += longint'(tap_line[DEPTH-1-2*h+j]) * longint'(coef_q[j]);
    acc = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return sample_t'(acc);
  endfunction

  function automatic void shift_tap_line(sample_t s);
    for (int i = 0; i < DEPTH - 1; i++) tap_line[i] = tap_line[i+1];
    tap_line[DEPTH-1] = s;
  endfunction

  // one accepted sample: update the window and queue what it releases
  function automatic void predict_line_step(sample_t s, bit line_end);
    int h;
    int count;
    int pre;
    h = int'(half_q);
    if (line_fill == 0) begin
      foreach (tap_line[i]) tap_line[i] = s;
    end else begin
      shift_tap_line(s);
    end
    if (line_fill < DEPTH) line_fill++;
    if (!line_end) begin
      if (line_fill > h) filtered_expected.push_back('{tap_sum(h), 1'b0});
    end else begin
      // short lines emit one output per sample, clamped at both ends
      if (line_fill > h) begin
        count = h + 1;
        pre = 0;
      end else begin
        count = line_fill;
        pre = h + 1 - line_fill;
      end
      repeat (pre) shift_tap_line(s);
      for (int k = 0; k < count; k++) begin
        if (k > 0) shift_tap_line(s);
        filtered_expected.push_back('{tap_sum(h), k + 1 == count});
      end
      line_fill = 0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_sample(input sample_t s, input bit line_end);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(s);
    in_tlast  <= line_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_line_step(s, line_end);
    samples_sent++;
  endtask

  // drop valid, wait for every pending output, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (filtered_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_HALF_WIDTH) half_q = value[HALF_W-1:0];
    else coef_q[int'(idx) - int'(REG_COEF_0)] = sample_t'(value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_kernel(input int h);
    settle();
    write_reg(REG_HALF_WIDTH, CFG_DATA_W'(h));
    for (int j = 0; j < NUM_COEF; j++)
      write_reg(reg_index_t'(int'(REG_COEF_0) + j), kernel_plan[j]);
  endtask

  task automatic test_reset_kernel();
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd200, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    // single sample line is no longer than the half width
    send_sample(16'sd1234, 1'b1);
  endtask

  task automatic test_saturation_and_short_lines();
    foreach (kernel_plan[j]) kernel_plan[j] = 16'sd32767;
    program_kernel(3);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b1);
    foreach (kernel_plan[j]) kernel_plan[j] = -16'sd32768;
    program_kernel(3);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
  endtask

  task automatic test_rounding_single_tap();
    foreach (kernel_plan[j]) kernel_plan[j] = 16'sd0;
    kernel_plan[0] = 16'sd16384;
    program_kernel(0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd3, 1'b1);
  endtask

  task automatic test_half_width_mid_line();
    kernel_plan = '{16'sd4096, -16'sd8192, 16'sd12288, 16'sd16384,
                    16'sd12288, -16'sd8192, 16'sd4096};
    program_kernel(1);
    send_sample(16'sd500, 1'b0);
    send_sample(-16'sd700, 1'b0);
    send_sample(16'sd900, 1'b0);
    settle();
    write_reg(REG_HALF_WIDTH, CFG_DATA_W'(3));
    send_sample(16'sd1100, 1'b0);
    send_sample(-16'sd1300, 1'b0);
    settle();
    write_reg(REG_HALF_WIDTH, CFG_DATA_W'(0));
    send_sample(16'sd1500, 1'b1);
  endtask

  function automatic sample_t random_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
    if (r < 4) return sample_t'($urandom_range(0, 511) - 256);
    return sample_t'($urandom());
  endfunction

  function automatic sample_t random_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
    if (r < 7) return sample_t'($urandom_range(0, 16383) - 8192);
    return sample_t'($urandom());
  endfunction

  task automatic test_random_lines();
    int first;
    int len;
    int r;
    int switch_at;
    first = samples_sent;
    while (samples_sent - first < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 3) begin
        foreach (kernel_plan[j]) kernel_plan[j] = random_coef();
        program_kernel($urandom_range(0, MAX_HALF));
      end
      no_gaps   = ($urandom_range(0, 3) == 0);
      no_stalls = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) len = $urandom_range(1, 3);
      else if (r < 75) len = $urandom_range(1, 8);
      else len = $urandom_range(9, 20);
      switch_at = ($urandom_range(0, 9) == 0 && len > 2) ? $urandom_range(1, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == switch_at) begin
          settle();
          write_reg(REG_HALF_WIDTH, CFG_DATA_W'($urandom_range(0, MAX_HALF)));
        end
        send_sample(random_sample(), i == len - 1);
      end
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    if (!no_stalls && stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected output %0d last %0b",
                                  $signed(out_tdata[SAMPLE_WIDTH-1:0]), out_tlast));
      end else begin
        want = filtered_expected.pop_front();
        if (out_tdata[SAMPLE_WIDTH-1:0] !== want.filtered)
          report_mismatch($sformatf("filtered %0d, expected %0d",
                                    $signed(out_tdata[SAMPLE_WIDTH-1:0]), want.filtered));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_tlast, want.last));
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    half_q = 2'd1;
    foreach (coef_q[j]) coef_q[j] = 16'sd0;
    coef_q[0] = 16'sd8192;
    coef_q[1] = 16'sd16384;
    coef_q[2] = 16'sd8192;
    foreach (tap_line[i]) tap_line[i] = 16'sd0;
    line_fill = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_kernel();
    test_saturation_and_short_lines();
    test_rounding_single_tap();
    test_half_width_mid_line();
    test_random_lines();
    settle();
    if (mismatch_count == 0 && filtered_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
